>>> hw/rtl/u8d_pkg.sv
package u8d_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int Q_DEPTH = 2;
  localparam int CP_W = 21;
  localparam int ERRPOS_W = 16;

  localparam logic [1:0] KIND_CODE  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [3:0] ST_ACCEPT = 4'd0;
  localparam logic [3:0] ST_REJECT = 4'd1;
  localparam logic [3:0] ST_START  = 4'd9;
  localparam int NUM_STATES = 10;

  typedef struct packed {
    logic [3:0] cls;
    logic [7:0] mask;
  } byte_info_t;

  typedef struct packed {
    logic       term;
    logic [3:0] cls;
    logic [7:0] payload;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic halted;
    logic at_start;
  } bk_status_t;

  localparam logic [3:0] NEXT_STATE [NUM_STATES][16] = '{
    '{4'd0,4'd1,4'd1,4'd1,4'd8,4'd7,4'd6,4'd4,4'd5,4'd4,4'd3,4'd2,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd0,4'd0,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd2,4'd2,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd2,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd4,4'd4,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd4,4'd4,4'd4,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd4,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd0,4'd1,4'd1,4'd1,4'd8,4'd7,4'd6,4'd4,4'd5,4'd4,4'd3,4'd2,4'd1,4'd1,4'd1,4'd1}
  };

  function automatic byte_info_t classify(input logic [7:0] b);
    byte_info_t r;
    if (b < 8'h80) begin
      r = '{cls: 4'd0, mask: 8'h00};
    end else if (b < 8'h90) begin
      r = '{cls: 4'd3, mask: 8'h80};
    end else if (b < 8'hA0) begin
      r = '{cls: 4'd2, mask: 8'h80};
    end else if (b < 8'hC0) begin
      r = '{cls: 4'd1, mask: 8'h80};
    end else if (b < 8'hC2) begin
      r = '{cls: 4'd12, mask: 8'hC0};
    end else if (b < 8'hE0) begin
      r = '{cls: 4'd11, mask: 8'hC0};
    end else if (b == 8'hE0) begin
      r = '{cls: 4'd10, mask: 8'hE0};
    end else if (b < 8'hED) begin
      r = '{cls: 4'd9, mask: 8'hE0};
    end else if (b == 8'hED) begin
      r = '{cls: 4'd8, mask: 8'hE0};
    end else if (b < 8'hF0) begin
      r = '{cls: 4'd7, mask: 8'hE0};
    end else if (b == 8'hF0) begin
      r = '{cls: 4'd6, mask: 8'hF0};
    end else if (b < 8'hF4) begin
      r = '{cls: 4'd5, mask: 8'hF0};
    end else if (b == 8'hF4) begin
      r = '{cls: 4'd4, mask: 8'hF0};
    end else begin
      r = '{cls: 4'd12, mask: 8'hF0};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/utf8_dfa_decoder_core.sv
// UTF-8 stream decoder.
// Input channel: in_valid/in_ready with in_byte, one raw byte per transaction.
//   A zero byte terminates the string and always yields an end-of-string result.
// Output channel: out_valid/out_ready with out_result_kind (0 code point,
//   1 invalid byte, 2 end of string), out_code_point, out_error_position.
//   A byte that completes a character yields a code point; a rejected byte
//   yields an error with its zero-based position, and the rest of the string
//   up to the terminator is dropped. Other bytes yield nothing.
// An accepted byte passes through the queue, then the output register in the back end.
// Throughput: one byte per cycle while out_ready keeps the output register free;
//   a two-entry queue sits between classifier and back end.
// Reset (rst_n low, synchronous) empties the queue and the output register
//   and returns the decoder to its start state with position zero.
// When out_ready is low the result is held; the queue then fills and
//   in_ready drops after at most two more bytes.
module utf8_dfa_decoder_core #(
  parameter int POSITION_BITS = u8d_pkg::POSITION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_result_kind,
  output logic [u8d_pkg::CP_W-1:0]     out_code_point,
  output logic [u8d_pkg::ERRPOS_W-1:0] out_error_position
);
  import u8d_pkg::*;

  q_status_t  q_stat;
  q_entry_t   q_wdata, q_rdata;
  logic       q_push, q_pop;
  bk_status_t bk_stat;

  u8d_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  u8d_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  u8d_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (!q_stat.empty),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_code_point     (out_code_point),
    .out_error_position (out_error_position),
    .stat               (bk_stat)
  );

`ifndef NO_ASSERTIONS
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_rdata.term) |=> (bk_stat.at_start && !bk_stat.halted))
    else $error("terminator did not reset decoder");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !$past(out_valid && !out_ready) && out_result_kind == KIND_ERROR
     && out_valid) |-> 1'b1 ##0 (bk_stat.halted || !out_valid ||
     out_result_kind != KIND_ERROR))
    else $error("error result without halt");

  a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!q_stat.empty && (!out_valid || out_ready)))
    else $error("back end popped without room");

  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_END) |->
      (out_code_point == '0 && out_error_position == '0))
    else $error("end marker carries payload");
`endif

endmodule

>>> hw/rtl/u8d_front.sv
module u8d_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  u8d_pkg::q_status_t q_stat,
  output logic              q_push,
  output u8d_pkg::q_entry_t q_wdata
);
  import u8d_pkg::*;

  byte_info_t info;

  always_comb begin
    info = classify(in_byte);
    q_wdata.term    = (in_byte == 8'h00);
    q_wdata.cls     = info.cls;
    q_wdata.payload = in_byte ^ info.mask;
  end

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

endmodule

>>> hw/rtl/u8d_queue.sv
module u8d_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  u8d_pkg::q_entry_t  wdata,
  input  logic               pop,
  output u8d_pkg::q_entry_t  rdata,
  output u8d_pkg::q_status_t stat
);
  import u8d_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  q_entry_t         mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/u8d_back.sv
module u8d_back #(
  parameter int POSITION_BITS = u8d_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  u8d_pkg::q_entry_t               q_rdata,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_result_kind,
  output logic [u8d_pkg::CP_W-1:0]        out_code_point,
  output logic [u8d_pkg::ERRPOS_W-1:0]    out_error_position,
  output u8d_pkg::bk_status_t             stat
);
  import u8d_pkg::*;

  localparam int PEXT_W = (POSITION_BITS > ERRPOS_W) ? POSITION_BITS : ERRPOS_W;

  logic [3:0]               state_r, state_nxt;
  logic [CP_W-1:0]          accum_r, accum_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     halted_r, halted_nxt;

  logic                     ovalid_r, ovalid_nxt;
  logic [1:0]               okind_r, okind_nxt;
  logic [CP_W-1:0]          ocode_r, ocode_nxt;
  logic [ERRPOS_W-1:0]      opos_r, opos_nxt;

  logic [3:0]               st_cur, st_new;
  logic [CP_W-1:0]          acc_new;
  logic [PEXT_W-1:0]        pos_ext;
  logic [ERRPOS_W-1:0]      err_pos;

  assign q_pop = q_valid && (!ovalid_r || out_ready);

  always_comb begin
    st_cur  = (state_r < 4'(NUM_STATES)) ? state_r : ST_REJECT;
    st_new  = NEXT_STATE[st_cur][q_rdata.cls];
    acc_new = {accum_r[CP_W-7:0], 6'b0} | {{(CP_W-8){1'b0}}, q_rdata.payload};
    pos_ext = PEXT_W'(pos_r);
    err_pos = (pos_ext > PEXT_W'({ERRPOS_W{1'b1}})) ? {ERRPOS_W{1'b1}}
                                                    : pos_ext[ERRPOS_W-1:0];

    state_nxt  = state_r;
    accum_nxt  = accum_r;
    pos_nxt    = pos_r;
    halted_nxt = halted_r;
    ovalid_nxt = ovalid_r && !out_ready;
    okind_nxt  = okind_r;
    ocode_nxt  = ocode_r;
    opos_nxt   = opos_r;

    if (q_pop) begin
      if (q_rdata.term) begin
        state_nxt  = ST_START;
        accum_nxt  = '0;
        pos_nxt    = '0;
        halted_nxt = 1'b0;
        ovalid_nxt = 1'b1;
        okind_nxt  = KIND_END;
        ocode_nxt  = '0;
        opos_nxt   = '0;
      end else if (!halted_r) begin
        state_nxt = st_new;
        accum_nxt = acc_new;
        if (pos_r != {POSITION_BITS{1'b1}}) begin
          pos_nxt = pos_r + 1'b1;
        end
        if (st_new == ST_ACCEPT) begin
          accum_nxt  = '0;
          ovalid_nxt = 1'b1;
          okind_nxt  = KIND_CODE;
          ocode_nxt  = acc_new;
          opos_nxt   = '0;
        end else if (st_new == ST_REJECT) begin
          halted_nxt = 1'b1;
          ovalid_nxt = 1'b1;
          okind_nxt  = KIND_ERROR;
          ocode_nxt  = '0;
          opos_nxt   = err_pos;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_START;
      accum_r  <= '0;
      pos_r    <= '0;
      halted_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      accum_r  <= accum_nxt;
      pos_r    <= pos_nxt;
      halted_r <= halted_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    okind_r <= okind_nxt;
    ocode_r <= ocode_nxt;
    opos_r  <= opos_nxt;
  end

  assign out_valid          = ovalid_r;
  assign out_result_kind    = okind_r;
  assign out_code_point     = ocode_r;
  assign out_error_position = opos_r;
  assign stat.halted        = halted_r;
  assign stat.at_start      = (state_r == ST_START) && (pos_r == '0);

endmodule

>>> sim/tb_utf8_dfa_decoder_core.sv
`timescale 1ns / 1ps

module tb_utf8_dfa_decoder_core;
  import u8d_pkg::*;

  typedef struct packed {
    logic [1:0]          kind;
    logic [CP_W-1:0]     cp;
    logic [ERRPOS_W-1:0] pos;
  } utf8_result_t;

  localparam int POS_BITS = POSITION_BITS_DEF;
  localparam int LONG_HOLD = 60;
  localparam int RANDOM_BYTES = 1350;
  localparam int LONG_BYTES = 120;

  localparam logic [3:0] DFA_NEXT [10][16] = '{
    '{4'd0,4'd1,4'd1,4'd1,4'd8,4'd7,4'd6,4'd4,4'd5,4'd4,4'd3,4'd2,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd0,4'd0,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd2,4'd2,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd2,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd4,4'd4,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd4,4'd4,4'd4,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd4,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd0,4'd1,4'd1,4'd1,4'd8,4'd7,4'd6,4'd4,4'd5,4'd4,4'd3,4'd2,4'd1,4'd1,4'd1,4'd1}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_byte = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_result_kind;
  logic [CP_W-1:0]     out_code_point;
  logic [ERRPOS_W-1:0] out_error_position;

  utf8_dfa_decoder_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_code_point     (out_code_point),
    .out_error_position (out_error_position)
  );

  // decoder mirror
  logic [3:0]          dec_state = ST_START;
  logic [CP_W-1:0]     dec_accum = '0;
  logic [POS_BITS-1:0] dec_pos = '0;
  logic                dec_halted = 1'b0;

  utf8_result_t decoded_q[$];
  utf8_result_t got_want;

  bit idle_en = 1'b1;
  bit long_hold = 1'b0;
  int n_err = 0;
  int n_checked = 0;
  int n_sent = 0;
  int n_live = 0;
  int n_cp = 0;
  int n_bad = 0;
  int n_end = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Timeout: %0d results still pending", decoded_q.size());
    $display("Some tests failed");
    $finish;
  end

  // {class, lead mask}
  function automatic logic [11:0] byte_class_mask(input logic [7:0] b);
    if (b < 8'h80) return {4'd0, 8'h00};
    if (b < 8'h90) return {4'd3, 8'h80};
    if (b < 8'hA0) return {4'd2, 8'h80};
    if (b < 8'hC0) return {4'd1, 8'h80};
    if (b < 8'hC2) return {4'd12, 8'hC0};
    if (b < 8'hE0) return {4'd11, 8'hC0};
    if (b == 8'hE0) return {4'd10, 8'hE0};
    if (b < 8'hED) return {4'd9, 8'hE0};
    if (b == 8'hED) return {4'd8, 8'hE0};
    if (b < 8'hF0) return {4'd7, 8'hE0};
    if (b == 8'hF0) return {4'd6, 8'hF0};
    if (b < 8'hF4) return {4'd5, 8'hF0};
    if (b == 8'hF4) return {4'd4, 8'hF0};
    return {4'd12, 8'hF0};
  endfunction

  task automatic decoder_clear();
    dec_state = ST_START;
    dec_accum = '0;
    dec_pos = '0;
    dec_halted = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [11:0] cm;
    logic [3:0] cur;
    utf8_result_t r;
    r = '0;
    if (b == 8'h00) begin
      r.kind = KIND_END;
      decoded_q.push_back(r);
      decoder_clear();
      n_end++;
      n_live++;
      return;
    end
    if (dec_halted) return;
    n_live++;
    cm = byte_class_mask(b);
    cur = (dec_state < NUM_STATES) ? dec_state : ST_REJECT;
    dec_state = DFA_NEXT[cur][cm[11:8]];
    dec_accum = {dec_accum[CP_W-7:0], 6'b0} | {{(CP_W-8){1'b0}}, b ^ cm[7:0]};
    if (dec_state == ST_ACCEPT) begin
      r.kind = KIND_CODE;
      r.cp = dec_accum;
      decoded_q.push_back(r);
      dec_accum = '0;
      n_cp++;
    end else if (dec_state == ST_REJECT) begin
      r.kind = KIND_ERROR;
      r.pos = (dec_pos > 16'hFFFF) ? 16'hFFFF : dec_pos[ERRPOS_W-1:0];
      decoded_q.push_back(r);
      dec_halted = 1'b1;
      n_bad++;
    end
    if (dec_pos != {POS_BITS{1'b1}}) dec_pos = dec_pos + 1'b1;
  endtask

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = (idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    decode_byte(b);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic push_code_point(input logic [CP_W-1:0] cp);
    if (cp < 'h80) begin
      push_byte(cp[7:0]);
    end else if (cp < 'h800) begin
      push_byte({3'b110, cp[10:6]});
      push_byte({2'b10, cp[5:0]});
    end else if (cp < 'h10000) begin
      push_byte({4'b1110, cp[15:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end else begin
      push_byte({5'b11110, cp[20:18]});
      push_byte({2'b10, cp[17:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_err++;
    if (n_err <= 50)
      $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want, n_checked);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(out_result_kind), 32'd0);
      end else begin
        got_want = decoded_q.pop_front();
        if (out_result_kind !== got_want.kind)
          report_mismatch("result_kind", 32'(out_result_kind), 32'(got_want.kind));
        if (out_code_point !== got_want.cp)
          report_mismatch("code_point", 32'(out_code_point), 32'(got_want.cp));
        if (out_error_position !== got_want.pos)
          report_mismatch("error_position", 32'(out_error_position),
                          32'(got_want.pos));
      end
      n_checked++;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : rx_drive
    int n;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 9);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_valid_chars();
    push_byte(8'h7F);
    push_byte(8'hC2); push_byte(8'h80);
    push_byte(8'hF0); push_byte(8'h90); push_byte(8'h80); push_byte(8'h80);
    push_byte(8'hF4); push_byte(8'h8F); push_byte(8'hBF); push_byte(8'hBF);
    push_byte(8'h00);
  endtask

  task automatic test_rejects();
    // invalid first byte, then ignored bytes until terminator
    push_byte(8'hFF); push_byte(8'h41); push_byte(8'h00);
    // stray continuation
    push_byte(8'h41); push_byte(8'h80); push_byte(8'h00);
    // overlong, then surrogate
    push_byte(8'hE0); push_byte(8'h80); push_byte(8'h00);
    push_byte(8'hED); push_byte(8'hA0); push_byte(8'h00);
  endtask

  task automatic test_truncated();
    push_byte(8'hE2); push_byte(8'h82); push_byte(8'h00);
    wait_drain();
  endtask

  task automatic test_backpressure();
    bit saved;
    saved = idle_en;
    idle_en = 1'b0;
    @(posedge clk);
    long_hold = 1'b1;
    for (int i = 0; i < 30; i++) push_byte(8'h41 + i[7:0]);
    push_byte(8'h00);
    wait_drain();
    idle_en = saved;
  endtask

  task automatic test_random_text();
    int base;
    int sel;
    int cat;
    logic [CP_W-1:0] cp;
    logic [7:0] lead;
    base = n_sent;
    while (n_sent - base < RANDOM_BYTES) begin
      if ($urandom_range(0, 99) == 0) idle_en = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        cat = $urandom_range(0, 9);
        case (cat)
          0, 1:    cp = CP_W'($urandom_range(1, 'h7F));
          2, 3:    cp = CP_W'($urandom_range('h80, 'h7FF));
          4, 5:    cp = CP_W'($urandom_range('h800, 'hFFFF));
          6, 7, 8: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
          default: cp = CP_W'($urandom_range('h110000, 'h1FFFFF));
        endcase
        push_code_point(cp);
      end else if (sel < 80) begin
        push_byte(8'h00);
      end else if (sel < 90) begin
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        // broken sequence: lead byte, optionally a continuation byte, then a random byte
        lead = 8'($urandom_range(8'hC0, 8'hFF));
        push_byte(lead);
        if ($urandom_range(0, 1)) push_byte({2'b10, 6'($urandom_range(0, 63))});
        push_byte(8'($urandom_range(0, 255)));
      end
    end
    push_byte(8'h00);
    wait_drain();
  endtask

  task automatic test_long_string();
    idle_en = 1'b0;
    for (int i = 0; i < LONG_BYTES; i++) push_byte(8'h41);
    push_byte(8'hFF);
    push_byte(8'h00);
    // position must restart after terminator
    push_byte(8'hFF);
    push_byte(8'h00);
    wait_drain();
  endtask

  initial begin
    decoder_clear();
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_valid_chars();
    test_rejects();
    test_truncated();
    test_backpressure();
    test_random_text();
    test_long_string();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes (%0d live); checked %0d results (%0d code points, %0d rejects, %0d ends)",
             n_sent, n_live, n_checked, n_cp, n_bad, n_end);
    $display("Covered valid/invalid/truncated strings, long output stall, long string positions");
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
